// File: design/pca_pkg.sv
// Shared constants, codes and controller/datapath interface types of the PID core.
`timescale 1ns / 1ps
package pca_pkg;

  // Data format.
  localparam int DataW  = 32;
  localparam int FracW  = 16;
  localparam int DtW    = 20;
  localparam int IupW   = 31;
  localparam int ProdW  = 2 * DataW;
  localparam int TermW  = ProdW - FracW;
  localparam int RawW   = TermW + 2;
  localparam int DivW   = DataW + 1 + FracW;
  localparam int DivCntW = $clog2(DivW);
  localparam int CfgIdxW = 3;

  // Actions of an input beat.
  localparam logic [1:0] ACT_MEAS  = 2'd0;
  localparam logic [1:0] ACT_RATE  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DT  = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;
  localparam logic [1:0] ST_LIM = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_KP     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KI     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KD     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OUT_LO = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OUT_HI = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_INT_LO = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_INT_HI = 3'd6;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_ED,
    OP_MUL_KP,
    OP_MUL_KI,
    OP_MUL_KD,
    OP_SUM,
    OP_RETRY,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] code;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       lim_bad;
    logic       dt_zero;
    logic       err_ovf;
    logic       need_div;
    logic       div_done;
    logic       deriv_ovf;
    logic       raw_ovf;
    logic       windup;
    logic       out_busy;
  } stat_t;

endpackage

// File: design/pid_controller_antiwindup_core.sv
// Top level of the fixed-point PID core with conditional-integration anti-windup.
`timescale 1ns / 1ps
// Fixed-point Q16.16 PID step with derivative on measurement and anti-windup.
// One input beat yields exactly one result beat. Beats are processed one at a
// time; the measured derivative comes from a restoring divider that
// produces one of its 49 quotient bits per cycle, and a saturating update
// reruns the sum with the old integral. All products go through one shared
// 32 x 32 multiplier. A finished result waits in an output register. The user
// must write configuration through cfg_we_i/cfg_idx_i/cfg_data_i while the
// core is idle; the core itself does not enforce this.
module pid_controller_antiwindup_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pca_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pca_pkg::DataW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        action_i,
  input  logic signed [pca_pkg::DataW-1:0]  setpoint_i,
  input  logic signed [pca_pkg::DataW-1:0]  measured_i,
  input  logic signed [pca_pkg::DataW-1:0]  given_rate_i,
  input  logic [pca_pkg::DtW-1:0]           step_time_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pca_pkg::DataW-1:0]  control_out_o,
  output logic [1:0]                        status_o
);
  import pca_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  pca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  pca_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .action_i      (action_i),
    .setpoint_i    (setpoint_i),
    .measured_i    (measured_i),
    .given_rate_i  (given_rate_i),
    .step_time_i   (step_time_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .control_out_o (control_out_o),
    .status_o      (status_o)
  );

endmodule

// File: design/pca_ctrl.sv
// Sequencing state machine of the PID core.
`timescale 1ns / 1ps
module pca_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pca_pkg::stat_t stat_i,
  output pca_pkg::cmd_t  cmd_o
);
  import pca_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_PREP = 10'b0000000010,
    S_DIV  = 10'b0000000100,
    S_MED  = 10'b0000001000,
    S_MKP  = 10'b0000010000,
    S_MKI  = 10'b0000100000,
    S_MKD  = 10'b0001000000,
    S_MSUM = 10'b0010000000,
    S_MCHK = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] code_q, code_d;
  logic       retry_q, retry_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    retry_d     = retry_q;
    cmd_o.op    = OP_NONE;
    cmd_o.code  = code_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          retry_d  = 1'b0;
          code_d   = ST_OK;
          state_d  = S_PREP;
        end
      end
      S_PREP: begin
        if (stat_i.action != ACT_MEAS && stat_i.action != ACT_RATE) begin
          state_d = S_FIN;
        end else if (stat_i.lim_bad) begin
          code_d  = ST_LIM;
          state_d = S_FIN;
        end else if (stat_i.dt_zero) begin
          code_d  = ST_DT;
          state_d = S_FIN;
        end else if (stat_i.err_ovf) begin
          code_d  = ST_OVF;
          state_d = S_FIN;
        end else if (stat_i.need_div) begin
          cmd_o.op = OP_DIV_INIT;
          state_d  = S_DIV;
        end else begin
          state_d = S_MED;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (stat_i.div_done) begin
          state_d = S_MED;
        end
      end
      S_MED: begin
        if (stat_i.deriv_ovf) begin
          code_d  = ST_OVF;
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_MUL_ED;
          state_d  = S_MKP;
        end
      end
      S_MKP: begin
        cmd_o.op = OP_MUL_KP;
        state_d  = S_MKI;
      end
      S_MKI: begin
        cmd_o.op = OP_MUL_KI;
        state_d  = S_MKD;
      end
      S_MKD: begin
        cmd_o.op = OP_MUL_KD;
        state_d  = S_MSUM;
      end
      S_MSUM: begin
        cmd_o.op = OP_SUM;
        state_d  = S_MCHK;
      end
      S_MCHK: begin
        if (stat_i.raw_ovf) begin
          code_d  = ST_OVF;
          state_d = S_FIN;
        end else if (stat_i.windup && !retry_q) begin
          // Conditional integration: redo the sum with the old integral.
          cmd_o.op = OP_RETRY;
          retry_d  = 1'b1;
          state_d  = S_MKI;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_OK;
      retry_q <= 1'b0;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      retry_q <= retry_d;
    end
  end

endmodule

// File: design/pca_datapath.sv
// Datapath of the PID core: configuration, state, divider, multiplier and result register.
`timescale 1ns / 1ps
module pca_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pca_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [pca_pkg::DataW-1:0]           cfg_data_i,
  input  logic [1:0]                          action_i,
  input  logic signed [pca_pkg::DataW-1:0]    setpoint_i,
  input  logic signed [pca_pkg::DataW-1:0]    measured_i,
  input  logic signed [pca_pkg::DataW-1:0]    given_rate_i,
  input  logic [pca_pkg::DtW-1:0]             step_time_i,
  input  pca_pkg::cmd_t                       cmd_i,
  output pca_pkg::stat_t                      stat_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pca_pkg::DataW-1:0]    control_out_o,
  output logic [1:0]                          status_o
);
  import pca_pkg::*;

  // Configuration registers.
  logic signed [DataW-1:0] kp_q, ki_q, kd_q, olo_q, ohi_q, ilo_q;
  logic [IupW-1:0]         ihi_q;
  // Controller state.
  logic signed [DataW-1:0] integ_q, last_q;
  logic                    have_q;
  // Working registers of one beat.
  logic [1:0]              act_q;
  logic signed [DataW:0]   err_q;
  logic signed [DataW-1:0] ms_q, deriv_q, ni_q;
  logic [DtW-1:0]          dt_q;
  logic                    dovf_q;
  logic signed [ProdW-1:0] mres_q;
  logic signed [TermW-1:0] t1_q, t2_q;
  logic signed [RawW-1:0]  raw_q;
  // Divider.
  logic [DivW-1:0]         dq_q;
  logic [DtW-1:0]          rem_q;
  logic [DivCntW-1:0]      cnt_q;
  logic                    dneg_q;
  // Result register.
  logic                    ovld_q;
  logic signed [DataW-1:0] oval_q;
  logic [1:0]              ost_q;

  logic signed [DataW-1:0] err32;
  assign err32 = err_q[DataW-1:0];

  // Configuration write with integral clamp on a limit write.
  logic signed [DataW-1:0] ilo_new;
  logic [IupW-1:0]         ihi_new;
  logic signed [DataW:0]   integ_cfg;
  always_comb begin
    ilo_new   = (cfg_idx_i == REG_INT_LO) ? $signed(cfg_data_i) : ilo_q;
    ihi_new   = (cfg_idx_i == REG_INT_HI) ? cfg_data_i[IupW-1:0] : ihi_q;
    integ_cfg = {integ_q[DataW-1], integ_q};
    if (integ_q < ilo_new) begin
      integ_cfg = {ilo_new[DataW-1], ilo_new};
    end else if (integ_cfg > $signed({2'b00, ihi_new})) begin
      integ_cfg = $signed({2'b00, ihi_new});
    end
  end

  // Divider step: one quotient bit per cycle.
  logic [DtW+1:0]  trial;
  logic            qbit;
  logic [DtW-1:0]  rem_d;
  logic [DivW-1:0] dq_d;
  logic            q_big;
  always_comb begin
    trial = {1'b0, rem_q, dq_q[DivW-1]} - {2'b00, dt_q};
    qbit  = !trial[DtW+1];
    rem_d = qbit ? trial[DtW-1:0] : {rem_q[DtW-2:0], dq_q[DivW-1]};
    dq_d  = {dq_q[DivW-2:0], qbit};
    q_big = (dq_d[DivW-1:DataW-1] != '0) &&
            !(dneg_q && dq_d[DivW-1:DataW] == '0 && dq_d[DataW-2:0] == '0);
  end

  // Difference for the measured derivative.
  logic signed [DataW:0] diff;
  logic [DataW:0]        dmag;
  assign diff = {ms_q[DataW-1], ms_q} - {last_q[DataW-1], last_q};
  assign dmag = diff[DataW] ? -diff : diff;

  // Shared multiplier with operand select.
  logic signed [DataW-1:0] ma, mb;
  always_comb begin
    ma = err32;
    mb = $signed({{(DataW-DtW){1'b0}}, dt_q});
    case (cmd_i.op)
      OP_MUL_KP: begin ma = kp_q; mb = err32;   end
      OP_MUL_KI: begin ma = ki_q; mb = ni_q;    end
      OP_MUL_KD: begin ma = kd_q; mb = deriv_q; end
      default: begin end
    endcase
  end

  // New integral, clamped to its limits.
  logic signed [TermW:0]   isum;
  logic signed [DataW-1:0] iclamp;
  always_comb begin
    isum = $signed({{(TermW-DataW+1){integ_q[DataW-1]}}, integ_q}) +
           $signed({mres_q[ProdW-1], mres_q[ProdW-1:FracW]});
    if (isum < $signed({{(TermW-DataW+1){ilo_q[DataW-1]}}, ilo_q})) begin
      iclamp = ilo_q;
    end else if (isum > $signed({{(TermW-IupW+1){1'b0}}, ihi_q})) begin
      iclamp = $signed({1'b0, ihi_q});
    end else begin
      iclamp = isum[DataW-1:0];
    end
  end

  // Checks on the output sum.
  logic signed [RawW-1:0] olo_x, ohi_x;
  logic signed [DataW-1:0] oclamp;
  assign olo_x = {{(RawW-DataW){olo_q[DataW-1]}}, olo_q};
  assign ohi_x = {{(RawW-DataW){ohi_q[DataW-1]}}, ohi_q};
  always_comb begin
    if (raw_q < olo_x) begin
      oclamp = olo_q;
    end else if (raw_q > ohi_x) begin
      oclamp = ohi_q;
    end else begin
      oclamp = raw_q[DataW-1:0];
    end
  end

  always_comb begin
    stat_o.action    = act_q;
    stat_o.lim_bad   = (olo_q > ohi_q) || (ilo_q > 0);
    stat_o.dt_zero   = (dt_q == '0);
    stat_o.err_ovf   = (err_q[DataW] != err_q[DataW-1]);
    stat_o.need_div  = (act_q == ACT_MEAS) && have_q;
    stat_o.div_done  = (cnt_q == DivCntW'(DivW - 1));
    stat_o.deriv_ovf = dovf_q;
    stat_o.raw_ovf   = (raw_q[RawW-1:DataW-1] != '0) && (raw_q[RawW-1:DataW-1] != '1);
    stat_o.windup    = ((raw_q > ohi_x) && (err32 > 0)) || ((raw_q < olo_x) && (err32 < 0));
    stat_o.out_busy  = ovld_q && !out_ready_i;
  end

  // Control registers: configuration, state and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      olo_q   <= {1'b1, {(DataW-1){1'b0}}};
      ohi_q   <= {1'b0, {(DataW-1){1'b1}}};
      ilo_q   <= {1'b1, {(DataW-1){1'b0}}};
      ihi_q   <= '1;
      integ_q <= '0;
      last_q  <= '0;
      have_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_KP:     kp_q  <= cfg_data_i;
          REG_KI:     ki_q  <= cfg_data_i;
          REG_KD:     kd_q  <= cfg_data_i;
          REG_OUT_LO: olo_q <= cfg_data_i;
          REG_OUT_HI: ohi_q <= cfg_data_i;
          REG_INT_LO: ilo_q <= cfg_data_i;
          REG_INT_HI: ihi_q <= cfg_data_i[IupW-1:0];
          default: begin end
        endcase
        if ((cfg_idx_i == REG_INT_LO || cfg_idx_i == REG_INT_HI) && ilo_new <= 0) begin
          integ_q <= integ_cfg[DataW-1:0];
        end
      end
      if (out_ready_i) begin
        ovld_q <= 1'b0;
      end
      if (cmd_i.op == OP_FINISH) begin
        ovld_q <= 1'b1;
        if (act_q == ACT_CLEAR) begin
          integ_q <= '0;
          last_q  <= '0;
          have_q  <= 1'b0;
        end else if (cmd_i.code == ST_OK && (act_q == ACT_MEAS || act_q == ACT_RATE)) begin
          integ_q <= ni_q;
          last_q  <= ms_q;
          have_q  <= 1'b1;
        end
      end
    end
  end

  // Working registers of the beat in flight.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        act_q   <= action_i;
        err_q   <= {setpoint_i[DataW-1], setpoint_i} - {measured_i[DataW-1], measured_i};
        ms_q    <= measured_i;
        dt_q    <= step_time_i;
        deriv_q <= (action_i == ACT_RATE) ? given_rate_i : '0;
        dovf_q  <= 1'b0;
      end
      OP_DIV_INIT: begin
        dq_q   <= {dmag, {FracW{1'b0}}};
        rem_q  <= '0;
        cnt_q  <= '0;
        dneg_q <= diff[DataW];
      end
      OP_DIV_STEP: begin
        dq_q  <= dq_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q + 1'b1;
        if (stat_o.div_done) begin
          dovf_q  <= q_big;
          deriv_q <= dneg_q ? -$signed(dq_d[DataW-1:0]) : $signed(dq_d[DataW-1:0]);
        end
      end
      OP_MUL_ED: begin
        mres_q <= ma * mb;
      end
      OP_MUL_KP: begin
        ni_q   <= iclamp;
        mres_q <= ma * mb;
      end
      OP_MUL_KI: begin
        t1_q   <= mres_q[ProdW-1:FracW];
        mres_q <= ma * mb;
      end
      OP_MUL_KD: begin
        t2_q   <= mres_q[ProdW-1:FracW];
        mres_q <= ma * mb;
      end
      OP_SUM: begin
        raw_q <= RawW'(t1_q) + RawW'(t2_q) - RawW'($signed(mres_q[ProdW-1:FracW]));
      end
      OP_RETRY: begin
        ni_q   <= integ_q;
        // Keep the proportional term in the product register for the rerun.
        mres_q <= {t1_q, {FracW{1'b0}}};
      end
      OP_FINISH: begin
        ost_q  <= cmd_i.code;
        oval_q <= (cmd_i.code == ST_OK && (act_q == ACT_MEAS || act_q == ACT_RATE)) ?
                  oclamp : '0;
      end
      default: begin end
    endcase
  end

  assign out_valid_o   = ovld_q;
  assign control_out_o = oval_q;
  assign status_o      = ost_q;

endmodule

// File: dv/pid_controller_antiwindup_core_chk.sv
// Checker that predicts and compares the result beats of the PID core.
`timescale 1ns / 1ps
module pid_controller_antiwindup_core_chk (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pca_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [pca_pkg::DataW-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [1:0]                       action_i,
  input  logic signed [pca_pkg::DataW-1:0] setpoint_i,
  input  logic signed [pca_pkg::DataW-1:0] measured_i,
  input  logic signed [pca_pkg::DataW-1:0] given_rate_i,
  input  logic [pca_pkg::DtW-1:0]          step_time_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic signed [pca_pkg::DataW-1:0] control_out_i,
  input  logic [1:0]                       status_i,
  output int                               fail_cnt_o,
  output int                               pending_o
);
  import pca_pkg::*;

  typedef struct packed {
    logic signed [DataW-1:0] ctl;
    logic [1:0]              st;
  } pid_res_t;

  // Shadow registers and controller state.
  longint kp, ki, kd, out_lo, out_hi, int_lo, int_hi;
  longint integ_q, last_meas_q;
  bit     have_meas_q;
  pid_res_t res_q[$];

  function automatic bit fits_data(longint v);
    return v >= -(64'sd1 <<< (DataW - 1)) && v <= (64'sd1 <<< (DataW - 1)) - 1;
  endfunction

  // Q16.16 product rounded toward minus infinity; operands fit in 32 bits,
  // so the 64-bit product never wraps.
  function automatic longint qprod(longint a, longint b);
    return (a * b) >>> FracW;
  endfunction

  function automatic bit pid_output(longint err, longint integ, longint drv,
                                    output longint raw);
    raw = qprod(kp, err) + qprod(ki, integ) - qprod(kd, drv);
    return fits_data(raw);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Work out the result of one input beat and advance the shadow state.
  function automatic pid_res_t pid_step(logic [1:0] act, longint sp, longint ms,
                                        longint rate, longint dt);
    pid_res_t r;
    longint   drv, err, ni, raw;
    r.ctl = '0;
    r.st  = ST_OK;
    drv   = 0;
    if (act == ACT_CLEAR) begin
      integ_q     = 0;
      last_meas_q = 0;
      have_meas_q = 1'b0;
      return r;
    end
    if (act != ACT_MEAS && act != ACT_RATE) return r;
    if (out_lo > out_hi || int_lo > 0) begin
      r.st = ST_LIM;
    end else if (dt == 0) begin
      r.st = ST_DT;
    end else begin
      if (act == ACT_RATE) drv = rate;
      else if (have_meas_q) drv = ((ms - last_meas_q) * (64'sd1 <<< FracW)) / dt;
      err = sp - ms;
      if (!fits_data(drv) || !fits_data(err)) begin
        r.st = ST_OVF;
      end else begin
        ni = clip(integ_q + qprod(err, dt), int_lo, int_hi);
        if (!pid_output(err, ni, drv, raw)) begin
          r.st = ST_OVF;
        end else if ((raw > out_hi && err > 0) || (raw < out_lo && err < 0)) begin
          // Conditional integration: rerun with the integral held.
          ni = integ_q;
          if (!pid_output(err, ni, drv, raw)) r.st = ST_OVF;
        end
        if (r.st == ST_OK) begin
          integ_q     = ni;
          last_meas_q = ms;
          have_meas_q = 1'b1;
          r.ctl       = DataW'(clip(raw, out_lo, out_hi));
        end
      end
    end
    return r;
  endfunction

  // Track register writes, predict on each input beat, compare each output beat.
  always @(posedge clk_i or negedge rst_ni) begin
    pid_res_t got, want;
    if (!rst_ni) begin
      kp = 0; ki = 0; kd = 0;
      out_lo = -(64'sd1 <<< 31); out_hi = (64'sd1 <<< 31) - 1;
      int_lo = -(64'sd1 <<< 31); int_hi = (64'sd1 <<< 31) - 1;
      integ_q = 0; last_meas_q = 0; have_meas_q = 1'b0;
      fail_cnt_o = 0;
      res_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KP:     kp = longint'($signed(cfg_data_i));
          REG_KI:     ki = longint'($signed(cfg_data_i));
          REG_KD:     kd = longint'($signed(cfg_data_i));
          REG_OUT_LO: out_lo = longint'($signed(cfg_data_i));
          REG_OUT_HI: out_hi = longint'($signed(cfg_data_i));
          REG_INT_LO: int_lo = longint'($signed(cfg_data_i));
          REG_INT_HI: int_hi = longint'(cfg_data_i[IupW-1:0]);
          default: ;
        endcase
        if ((cfg_idx_i == REG_INT_LO || cfg_idx_i == REG_INT_HI) && int_lo <= 0)
          integ_q = clip(integ_q, int_lo, int_hi);
      end
      if (in_valid_i && in_ready_i)
        res_q.push_back(pid_step(action_i, longint'(setpoint_i), longint'(measured_i),
                                 longint'(given_rate_i), longint'(step_time_i)));
      if (out_valid_i && out_ready_i) begin
        got.ctl = control_out_i;
        got.st  = status_i;
        if (res_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("result beat with nothing outstanding: ctl=%0d st=%0d",
                     got.ctl, got.st);
        end else begin
          want = res_q.pop_front();
          if (got != want) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display("mismatch: ctl exp %0d got %0d, st exp %0d got %0d",
                       want.ctl, got.ctl, want.st, got.st);
          end
        end
      end
    end
    pending_o = res_q.size();
  end
endmodule

// File: dv/pid_controller_antiwindup_core_tb.sv
// Testbench top: stimulus, configuration phases and verdict for the PID core.
`timescale 1ns / 1ps
module pid_controller_antiwindup_core_tb;
  import pca_pkg::*;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx_i = '0;
  logic [DataW-1:0]        cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              action_i = ACT_MEAS;
  logic signed [DataW-1:0] setpoint_i = '0;
  logic signed [DataW-1:0] measured_i = '0;
  logic signed [DataW-1:0] given_rate_i = '0;
  logic [DtW-1:0]          step_time_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [DataW-1:0] control_out_o;
  logic [1:0]              status_o;
  int                      fail_cnt, pending;
  bit                      quiet;          // no idling on either side
  int                      hold_req = 0;   // long hold-offs asked for
  int                      hold_done = 0;  // long hold-offs carried out
  int                      idle_cycles = 0;

  localparam logic [DataW-1:0] MinV = 32'h8000_0000;
  localparam logic [DataW-1:0] MaxV = 32'h7FFF_FFFF;
  localparam int               IdleLimit = 20000;

  pid_controller_antiwindup_core dut (.*);

  pid_controller_antiwindup_core_chk chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .action_i, .setpoint_i, .measured_i,
    .given_rate_i, .step_time_i, .out_valid_i(out_valid_o), .out_ready_i,
    .control_out_i(control_out_o), .status_i(status_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver: random stalls, and one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_done) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_done++;
      end
      out_ready_i <= quiet || ($urandom_range(0, 99) >= 7);
    end
  end

  // Watchdog on cycles with no beat and no register write.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("[pid_controller_antiwindup_core] ERROR");
      $finish;
    end
  end

  function automatic logic [DataW-1:0] rnd_val();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    if (p < 85) return $urandom;
    case ($urandom_range(0, 3))
      0: return MinV;
      1: return MaxV;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [DtW-1:0] rnd_dt();
    int p;
    p = $urandom_range(0, 99);
    if (p < 3) return '0;
    if (p < 65) return DtW'($urandom_range(1, 16'h4000));
    return DtW'($urandom_range(1, 20'hFFFFF));
  endfunction

  // One input beat; valid stays high between back-to-back beats.
  task automatic send(logic [1:0] act, logic [DataW-1:0] sp, logic [DataW-1:0] ms,
                      logic [DataW-1:0] rate, logic [DtW-1:0] dt);
    bit hs;
    in_valid_i   <= 1'b1;
    action_i     <= act;
    setpoint_i   <= sp;
    measured_i   <= ms;
    given_rate_i <= rate;
    step_time_i  <= dt;
    do begin
      @(negedge clk_i);
      hs = in_ready_o;
      @(posedge clk_i);
    end while (!hs);
    if (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_rnd();
    int          p;
    logic [1:0]  act;
    p = $urandom_range(0, 99);
    act = (p < 55) ? ACT_MEAS : (p < 92) ? ACT_RATE : (p < 97) ? ACT_CLEAR : ACT_NOP;
    send(act, rnd_val(), rnd_val(), rnd_val(), rnd_dt());
  endtask

  // Let every outstanding result drain before touching the registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_all(logic [DataW-1:0] v[7]);
    for (int i = 0; i < 7; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= i[CfgIdxW-1:0];
      cfg_data_i <= v[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_one(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic rnd_config();
    logic [DataW-1:0] v[7];
    logic [DataW-1:0] a, b;
    for (int i = 0; i < 3; i++)
      v[i] = ($urandom_range(0, 3) == 0) ? rnd_val() :
             $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    a = rnd_val();
    b = rnd_val();
    v[3] = ($signed(a) < $signed(b)) ? a : b;
    v[4] = ($signed(a) < $signed(b)) ? b : a;
    v[5] = -$urandom_range(0, 32'h0100_0000);
    v[6] = $urandom_range(0, 32'h0100_0000) | ($urandom & 32'h8000_0000);
    write_all(v);
  endtask

  initial begin
    logic [DataW-1:0] cfg[7];
    quiet = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: gains 1.0, 0.5, 0.25; output limits +-100; integral +-50.
    cfg = '{32'h0001_0000, 32'h0000_8000, 32'h0000_4000, -32'h0064_0000,
            32'h0064_0000, -32'h0032_0000, 32'h0032_0000};
    write_all(cfg);
    send(ACT_MEAS, 32'h0002_0000, 32'h0001_0000, '0, 20'h1_0000);   // no previous sample
    send(ACT_MEAS, 32'h0002_0000, 32'h0001_8000, '0, 20'h0_8000);   // measured derivative
    send(ACT_RATE, 32'h0005_0000, '0, 32'hFFFF_0000, 20'h0_4000);
    send(ACT_MEAS, 32'h0070_0000, '0, '0, 20'hF_FFFF);              // saturation, held integral
    send(ACT_MEAS, -32'h0070_0000, '0, '0, 20'hF_FFFF);
    send(ACT_MEAS, 32'h0001_0000, 32'h0001_0000, '0, '0);           // zero step time
    send(ACT_MEAS, MaxV, MinV, '0, 20'h0_0001);                     // error overflow
    send(ACT_MEAS, MinV, MaxV, '0, 20'h0_0001);
    send(ACT_MEAS, '0, MinV, '0, 20'h0_0001);                       // error overflow, extreme rates
    send(ACT_RATE, '0, '0, MinV, 20'h0_0001);
    send(ACT_RATE, '0, '0, MaxV, 20'h0_0001);
    send(ACT_NOP, MaxV, MaxV, MaxV, 20'hF_FFFF);                    // unused action
    send(ACT_CLEAR, '0, '0, '0, '0);
    send(ACT_MEAS, '1, '1, '1, 20'h0_0001);
    drain();
    // Invalid limit pairs.
    write_one(REG_OUT_LO, 32'h0065_0000);
    send(ACT_MEAS, '0, '0, '0, 20'h1_0000);
    send(ACT_MEAS, '0, '0, '0, '0);
    drain();
    write_one(REG_OUT_LO, -32'h0064_0000);
    write_one(REG_INT_LO, 32'h0000_0001);
    send(ACT_RATE, '0, '0, '0, 20'h1_0000);
    drain();
    // Extremes of every register.
    cfg = '{MaxV, MinV, MaxV, MinV, MaxV, MinV, 32'hFFFF_FFFF};
    write_all(cfg);
    for (int i = 0; i < 5; i++) send_rnd();
    drain();
    cfg = '{MinV, MaxV, MinV, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, '0};
    write_all(cfg);
    for (int i = 0; i < 5; i++) send_rnd();
    drain();

    // Random phases with fresh settings each.
    for (int ph = 0; ph < 5; ph++) begin
      rnd_config();
      quiet = (ph == 1);
      for (int i = 0; i < 85; i++) begin
        if (ph == 2 && i == 20) hold_req++;
        if (ph == 3 && i == 40) drain();
        send_rnd();
      end
      drain();
    end
    quiet = 1'b0;

    repeat (70) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("[pid_controller_antiwindup_core] OK");
    else
      $display("[pid_controller_antiwindup_core] ERROR");
    $finish;
  end
endmodule
